// ===== sv/mrs_pkg.sv =====
// Shared types, codes and the CRC-16/Modbus byte update for the holding register file.
`default_nettype none
package mrs_pkg;

  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0]  FC_READ         = 8'h03;
  localparam logic [7:0]  EXC_FLAG        = 8'h80;
  localparam logic [7:0]  EXC_CODE        = 8'h01;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam int          LEN_W           = 9;
  localparam int          QDEPTH          = 2;

  typedef enum logic [1:0] {
    K_EXC = 2'd0,
    K_WS  = 2'd1,
    K_WM  = 2'd2,
    K_RD  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       fc;
    logic [7:0]       b2;
    logic [7:0]       addr;
    logic [7:0]       b4;
    logic [7:0]       b5;
    logic [LEN_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic idle;
    logic buf_release;
    logic dirty_any;
  } back_stat_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      if (r[0]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mrs_front.sv =====
// Front end: collects request bytes, checks the CRC and classifies complete frames.
`default_nettype none
module mrs_front #(
  parameter int FRAME_BYTES = 240
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rx_valid,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  frame_end,
  output logic                       rx_stall,
  input  wire logic                  q_full,
  output logic                       q_push,
  output mrs_pkg::desc_t             q_desc,
  input  wire logic                  buf_rd_en,
  input  wire logic [$clog2(FRAME_BYTES)-1:0] buf_a_hi,
  input  wire logic [$clog2(FRAME_BYTES)-1:0] buf_a_lo,
  output logic [7:0]                 buf_hi,
  output logic [7:0]                 buf_lo,
  input  wire logic                  buf_release
);

  localparam int AW = $clog2(FRAME_BYTES);

  logic [7:0] mem [FRAME_BYTES];
  logic [mrs_pkg::LEN_W-1:0] count;
  logic ovf;
  logic [15:0] c0, c1;
  logic [7:0] lb1, fc, b2, addr, b4, b5;
  logic wm_hold;

  logic acc, store, frame_ok, crc_ok;
  logic [7:0] b5v;
  mrs_pkg::kind_t kind;
  logic known;

  assign rx_stall = q_full | wm_hold;
  assign acc      = rx_valid & ~rx_stall;
  assign store    = acc && (count < mrs_pkg::LEN_W'(FRAME_BYTES));

  // A frame end whose byte was dropped means the frame overflowed.
  assign frame_ok = acc & frame_end & store & ~ovf & (count >= mrs_pkg::LEN_W'(5));
  assign crc_ok   = (lb1 == c1[7:0]) && (rx_byte == c1[15:8]);
  assign b5v      = (count == mrs_pkg::LEN_W'(5)) ? rx_byte : b5;

  always_comb begin
    kind  = mrs_pkg::K_EXC;
    known = 1'b1;
    if (crc_ok) begin
      case (fc)
        mrs_pkg::FC_WRITE_SINGLE: kind = mrs_pkg::K_WS;
        mrs_pkg::FC_WRITE_MULTI:  kind = mrs_pkg::K_WM;
        mrs_pkg::FC_READ:         kind = mrs_pkg::K_RD;
        default:                  known = 1'b0;
      endcase
    end
  end

  assign q_push      = frame_ok & known;
  assign q_desc.kind = kind;
  assign q_desc.fc   = fc;
  assign q_desc.b2   = b2;
  assign q_desc.addr = addr;
  assign q_desc.b4   = b4;
  assign q_desc.b5   = b5v;
  assign q_desc.len  = count + mrs_pkg::LEN_W'(1);

  always_ff @(posedge clk) begin
    if (store) mem[count[AW-1:0]] <= rx_byte;
    if (buf_rd_en) begin
      buf_hi <= mem[buf_a_hi];
      buf_lo <= mem[buf_a_lo];
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      lb1 <= rx_byte;
      case (count)
        mrs_pkg::LEN_W'(1): fc   <= rx_byte;
        mrs_pkg::LEN_W'(2): b2   <= rx_byte;
        mrs_pkg::LEN_W'(3): addr <= rx_byte;
        mrs_pkg::LEN_W'(4): b4   <= rx_byte;
        mrs_pkg::LEN_W'(5): b5   <= rx_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ovf     <= 1'b0;
      c0      <= mrs_pkg::CRC_INIT;
      c1      <= mrs_pkg::CRC_INIT;
      wm_hold <= 1'b0;
    end else begin
      if (acc && frame_end) begin
        count <= '0;
        ovf   <= 1'b0;
        c0    <= mrs_pkg::CRC_INIT;
        c1    <= mrs_pkg::CRC_INIT;
      end else if (store) begin
        count <= count + mrs_pkg::LEN_W'(1);
        c1    <= c0;
        c0    <= mrs_pkg::crc_upd(c0, rx_byte);
      end else if (acc) begin
        ovf <= 1'b1;
      end
      // The buffer stays frozen until a write multiple has read its data.
      if (q_push && kind == mrs_pkg::K_WM) wm_hold <= 1'b1;
      else if (buf_release) wm_hold <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mrs_queue.sv =====
// Two-entry queue of classified frame descriptors between the front and back ends.
`default_nettype none
module mrs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  mrs_pkg::desc_t      din,
  output logic                full,
  input  wire logic           pop,
  output mrs_pkg::desc_t      dout,
  output logic                empty
);

  mrs_pkg::desc_t ent [mrs_pkg::QDEPTH];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'(mrs_pkg::QDEPTH));
  assign empty = (cnt == 2'd0);
  assign dout  = ent[rp];

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (!push && pop) cnt <= cnt - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mrs_back.sv =====
// Back end: updates and reads the holding register file and sends the reply bytes.
`default_nettype none
module mrs_back #(
  parameter int NUM_REGS    = 80,
  parameter int FRAME_BYTES = 240,
  parameter int MAX_READ    = 29,
  parameter int NOSAVE_REG  = 79
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            slave_id,
  input  wire logic                  q_empty,
  input  mrs_pkg::desc_t             q_desc,
  output logic                       q_pop,
  output logic                       buf_rd_en,
  output logic [$clog2(FRAME_BYTES)-1:0] buf_a_hi,
  output logic [$clog2(FRAME_BYTES)-1:0] buf_a_lo,
  input  wire logic [7:0]            buf_hi,
  input  wire logic [7:0]            buf_lo,
  output logic                       tx_valid,
  output logic [7:0]                 tx_byte,
  output logic                       tx_last,
  input  wire logic                  tx_stall,
  output mrs_pkg::back_stat_t        stat
);

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int RAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_WRD  = 9'b000000010,
    ST_WCHK = 9'b000000100,
    ST_HDR  = 9'b000001000,
    ST_RRD  = 9'b000010000,
    ST_RHI  = 9'b000100000,
    ST_RLO  = 9'b001000000,
    ST_CRCL = 9'b010000000,
    ST_CRCH = 9'b100000000
  } state_t;

  state_t state, state_next;
  mrs_pkg::desc_t d;
  logic [7:0] idx, cnt;
  logic [2:0] hidx;
  logic [15:0] crc;
  logic hi_ok, lo_ok;

  logic [15:0] regs [NUM_REGS];
  logic [NUM_REGS-1:0] rvld, dirty;
  logic [15:0] rd_data;
  logic rd_vld;

  logic [8:0] ea;
  logic in_rng, rd_en, slot, last_i;
  logic [9:0] pos_hi, pos_lo;
  logic [15:0] cur, newv;
  logic wr_en;
  logic emit, emit_last, crc_add;
  logic [7:0] emit_byte, hdr_byte, cnt_in;
  logic hdr_last, is_exc, is_wr;

  assign ea     = {1'b0, d.addr} + {1'b0, idx};
  assign in_rng = ea < 9'(NUM_REGS);
  assign pos_hi = 10'd7 + {1'b0, idx, 1'b0};
  assign pos_lo = pos_hi + 10'd1;
  assign buf_a_hi = pos_hi[AW-1:0];
  assign buf_a_lo = pos_lo[AW-1:0];
  assign cur    = rd_vld ? rd_data : 16'h0000;
  assign slot   = ~tx_valid | ~tx_stall;
  assign last_i = (idx + 8'd1) == cnt;
  assign is_exc = (d.kind == mrs_pkg::K_EXC);
  assign is_wr  = (d.kind == mrs_pkg::K_WS) || (d.kind == mrs_pkg::K_WM);

  assign newv = (d.kind == mrs_pkg::K_WS) ? {d.b4, d.b5}
              : {hi_ok ? buf_hi : 8'h00, lo_ok ? buf_lo : 8'h00};
  assign wr_en = (state == ST_WCHK) && in_rng && (cur != newv);

  assign cnt_in = (q_desc.b5 > 8'(MAX_READ)) ? 8'(MAX_READ) : q_desc.b5;

  always_comb begin
    case (hidx)
      3'd0:    hdr_byte = slave_id;
      3'd1:    hdr_byte = is_exc ? (d.fc | mrs_pkg::EXC_FLAG) : d.fc;
      3'd2:    hdr_byte = is_exc ? mrs_pkg::EXC_CODE
                        : (d.kind == mrs_pkg::K_RD) ? {cnt[6:0], 1'b0} : d.b2;
      3'd3:    hdr_byte = d.addr;
      3'd4:    hdr_byte = d.b4;
      3'd5:    hdr_byte = d.b5;
      default: hdr_byte = 8'h00;
    endcase
  end
  assign hdr_last = is_wr ? (hidx == 3'd5) : (hidx == 3'd2);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    buf_rd_en  = 1'b0;
    emit       = 1'b0;
    emit_byte  = 8'h00;
    emit_last  = 1'b0;
    crc_add    = 1'b0;
    stat.buf_release = 1'b0;
    stat.idle        = (state == ST_IDLE);
    stat.dirty_any   = |dirty;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_desc.kind)
            mrs_pkg::K_WS: state_next = ST_WRD;
            mrs_pkg::K_WM: begin
              if (q_desc.b5 == 8'd0) begin
                state_next = ST_HDR;
                stat.buf_release = 1'b1;
              end else begin
                state_next = ST_WRD;
              end
            end
            default: state_next = ST_HDR;
          endcase
        end
      end
      ST_WRD: begin
        rd_en      = 1'b1;
        buf_rd_en  = 1'b1;
        state_next = ST_WCHK;
      end
      ST_WCHK: begin
        if (d.kind == mrs_pkg::K_WS || last_i) begin
          state_next = ST_HDR;
          stat.buf_release = (d.kind == mrs_pkg::K_WM);
        end else begin
          state_next = ST_WRD;
        end
      end
      ST_HDR: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = hdr_byte;
          crc_add   = 1'b1;
          if (hdr_last) begin
            if (d.kind == mrs_pkg::K_RD && cnt != 8'd0) state_next = ST_RRD;
            else state_next = ST_CRCL;
          end
        end
      end
      ST_RRD: begin
        rd_en      = 1'b1;
        state_next = ST_RHI;
      end
      ST_RHI: begin
        if (slot) begin
          emit       = 1'b1;
          emit_byte  = cur[15:8];
          crc_add    = 1'b1;
          state_next = ST_RLO;
        end
      end
      ST_RLO: begin
        if (slot) begin
          emit       = 1'b1;
          emit_byte  = cur[7:0];
          crc_add    = 1'b1;
          state_next = last_i ? ST_CRCL : ST_RRD;
        end
      end
      ST_CRCL: begin
        if (slot) begin
          emit       = 1'b1;
          emit_byte  = crc[7:0];
          state_next = ST_CRCH;
        end
      end
      ST_CRCH: begin
        if (slot) begin
          emit       = 1'b1;
          emit_byte  = crc[15:8];
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) regs[ea[RAW-1:0]] <= newv;
    if (rd_en) begin
      rd_data <= regs[ea[RAW-1:0]];
      rd_vld  <= in_rng & rvld[ea[RAW-1:0]];
    end
    if (state == ST_WRD) begin
      hi_ok <= pos_hi < {1'b0, d.len};
      lo_ok <= pos_lo < {1'b0, d.len};
    end
    if (q_pop) begin
      d   <= q_desc;
      cnt <= (q_desc.kind == mrs_pkg::K_RD) ? cnt_in : q_desc.b5;
    end
    if (emit && slot) begin
      tx_byte <= emit_byte;
      tx_last <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rvld     <= '0;
      dirty    <= '0;
      idx      <= 8'd0;
      hidx     <= 3'd0;
      crc      <= mrs_pkg::CRC_INIT;
      tx_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        rvld[ea[RAW-1:0]] <= 1'b1;
        if (ea != 9'(NOSAVE_REG)) dirty[ea[RAW-1:0]] <= 1'b1;
      end
      if (q_pop) begin
        idx  <= 8'd0;
        hidx <= 3'd0;
        crc  <= mrs_pkg::CRC_INIT;
      end else begin
        if ((state == ST_WCHK && state_next == ST_WRD) ||
            (state == ST_RLO && slot)) begin
          idx <= idx + 8'd1;
        end
        if (state == ST_HDR && slot) hidx <= hidx + 3'd1;
        if (crc_add) crc <= mrs_pkg::crc_upd(crc, emit_byte);
      end
      if (emit && slot) tx_valid <= 1'b1;
      else if (!tx_stall) tx_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/modbus_rtu_slave_register_file_core.sv =====
// Top level of the Modbus RTU slave holding register file.
//
//  channel   direction  transfer when           payload
//  rx        in         rx_valid & !rx_stall    rx_byte, frame_end
//  tx        out        tx_valid & !tx_stall    tx_byte, tx_last
//  cfg       in         cfg_valid & cfg_ready   cfg_data (slave_id)
//
// The front end never stalls mid-frame unless the descriptor queue is full
// or a write multiple still reads the buffer. A write passes through ST_WRD
// and ST_WCHK per register in the back end; a reply goes out at one byte per
// cycle unless tx stalls, plus an ST_RRD state per register read from the file.
// Reset clears the register file through per-entry valid bits, with no sweep.
// A stalled tx transfer holds its byte while the front end keeps receiving.
`default_nettype none
module modbus_rtu_slave_register_file_core #(
  parameter int NUM_REGS    = 80,
  parameter int FRAME_BYTES = 240,
  parameter int MAX_READ    = 29,
  parameter int NOSAVE_REG  = 79
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_end,
  output logic            tx_valid,
  input  wire logic       tx_stall,
  output logic [7:0]      tx_byte,
  output logic            tx_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam int AW = $clog2(FRAME_BYTES);

  logic [7:0] slave_id;
  logic q_full, q_empty, q_push, q_pop;
  mrs_pkg::desc_t push_desc, pop_desc;
  logic buf_rd_en;
  logic [AW-1:0] buf_a_hi, buf_a_lo;
  logic [7:0] buf_hi, buf_lo;
  mrs_pkg::back_stat_t bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) slave_id <= 8'd1;
    else if (cfg_valid && cfg_ready) slave_id <= cfg_data;
  end

  mrs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_byte(rx_byte), .frame_end(frame_end), .rx_stall(rx_stall),
    .q_full(q_full), .q_push(q_push), .q_desc(push_desc),
    .buf_rd_en(buf_rd_en), .buf_a_hi(buf_a_hi), .buf_a_lo(buf_a_lo),
    .buf_hi(buf_hi), .buf_lo(buf_lo), .buf_release(bk_stat.buf_release)
  );

  mrs_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .din(push_desc), .full(q_full),
    .pop(q_pop), .dout(pop_desc), .empty(q_empty)
  );

  mrs_back #(
    .NUM_REGS(NUM_REGS), .FRAME_BYTES(FRAME_BYTES),
    .MAX_READ(MAX_READ), .NOSAVE_REG(NOSAVE_REG)
  ) u_back (
    .clk(clk), .rst(rst), .slave_id(slave_id),
    .q_empty(q_empty), .q_desc(pop_desc), .q_pop(q_pop),
    .buf_rd_en(buf_rd_en), .buf_a_hi(buf_a_hi), .buf_a_lo(buf_a_lo),
    .buf_hi(buf_hi), .buf_lo(buf_lo),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .tx_last(tx_last), .tx_stall(tx_stall),
    .stat(bk_stat)
  );

  // The back end takes a new frame only once the previous reply is fully issued.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> bk_stat.idle)
    else $error("descriptor popped while back end busy");

  // Accepting bytes is throttled so that the queue never overflows.
  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("descriptor pushed into a full queue");

  // Dirty flags are only ever set; nothing in this block clears them.
  a_dirty_sticky: assert property (@(posedge clk) disable iff (rst)
    bk_stat.dirty_any |=> bk_stat.dirty_any)
    else $error("dirty flag cleared");

endmodule
`default_nettype wire

// ===== tb/sv/tb_modbus_rtu_slave_register_file_core.sv =====
// Self-checking testbench for the Modbus RTU slave holding register file core.
`default_nettype none
module tb_modbus_rtu_slave_register_file_core;

  localparam int NREGS   = 80;
  localparam int FBYTES  = 240;
  localparam int RDMAX   = 29;
  localparam int NOSAVE  = 79;
  localparam int LIMIT   = 1000000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       frame_end;
  logic       tx_valid;
  logic       tx_stall;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  modbus_rtu_slave_register_file_core dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte), .frame_end(frame_end),
    .tx_valid(tx_valid), .tx_stall(tx_stall), .tx_byte(tx_byte), .tx_last(tx_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow of the block state.
  logic [7:0]  station_id;
  logic [15:0] regs_shadow [NREGS];
  logic        dirty_shadow [NREGS];
  logic [7:0]  frame_shadow [FBYTES];
  int          frame_len;
  logic        frame_ovf;

  rx_item_t    pending_bytes[$];
  reply_byte_t expected_reply[$];
  int          mismatches;
  int          cycles;
  bit          hold_sender;

  function automatic logic [15:0] crc16(input logic [7:0] b[], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_reply(input logic [7:0] r[], input int n);
    logic [7:0]  full[];
    logic [15:0] c;
    reply_byte_t e;
    full = new[n + 2];
    for (int i = 0; i < n; i++) full[i] = r[i];
    c = crc16(r, n);
    full[n] = c[7:0];
    full[n + 1] = c[15:8];
    for (int i = 0; i < n + 2; i++) begin
      e.data = full[i];
      e.last = (i == n + 1);
      expected_reply.push_back(e);
    end
  endfunction

  function automatic void store_reg(input int a, input logic [15:0] v);
    if (a >= NREGS || regs_shadow[a] == v) return;
    if (a != NOSAVE) dirty_shadow[a] = 1'b1;
    regs_shadow[a] = v;
  endfunction

  function automatic logic [7:0] frame_byte(input int p, input int n);
    return (p < n && p < FBYTES) ? frame_shadow[p] : 8'h00;
  endfunction

  // Updates the shadow state and the expected reply for one accepted request byte.
  function automatic void predict_reply(input logic [7:0] b, input logic last);
    int          n, a, cnt;
    logic [7:0]  fc;
    logic [7:0]  r[];
    logic [7:0]  fr[];
    logic [15:0] c, v;
    if (frame_len < FBYTES) begin
      frame_shadow[frame_len] = b;
      frame_len++;
    end else frame_ovf = 1'b1;
    if (!last) return;
    n = frame_len;
    frame_len = 0;
    if (frame_ovf || n <= 5) begin
      frame_ovf = 1'b0;
      return;
    end
    fc = frame_shadow[1];
    a = frame_shadow[3];
    fr = new[n];
    for (int i = 0; i < n; i++) fr[i] = frame_shadow[i];
    c = crc16(fr, n - 2);
    r = new[RDMAX * 2 + 8];
    r[0] = station_id;
    if (fr[n - 2] != c[7:0] || fr[n - 1] != c[15:8]) begin
      r[1] = fc | mrs_pkg::EXC_FLAG;
      r[2] = mrs_pkg::EXC_CODE;
      push_reply(r, 3);
    end else if (fc == mrs_pkg::FC_WRITE_SINGLE || fc == mrs_pkg::FC_WRITE_MULTI) begin
      if (fc == mrs_pkg::FC_WRITE_SINGLE) store_reg(a, {fr[4], fr[5]});
      else begin
        cnt = fr[5];
        for (int i = 0; i < cnt; i++)
          store_reg(a + i, {frame_byte(7 + 2 * i, n), frame_byte(8 + 2 * i, n)});
      end
      r[1] = fc;
      for (int i = 2; i < 6; i++) r[i] = fr[i];
      push_reply(r, 6);
    end else if (fc == mrs_pkg::FC_READ) begin
      cnt = fr[5] > RDMAX ? RDMAX : fr[5];
      r[1] = mrs_pkg::FC_READ;
      r[2] = 8'(cnt * 2);
      for (int i = 0; i < cnt; i++) begin
        v = (a + i < NREGS) ? regs_shadow[a + i] : 16'h0000;
        r[3 + 2 * i] = v[15:8];
        r[4 + 2 * i] = v[7:0];
      end
      push_reply(r, 3 + 2 * cnt);
    end
  endfunction

  // Queues a frame; good_crc appends the correct CRC, otherwise a corrupted one.
  task automatic queue_frame(input logic [7:0] body[], input bit good_crc);
    logic [7:0]  fr[];
    logic [15:0] c;
    rx_item_t    it;
    int          n;
    n = body.size();
    fr = new[n + 2];
    for (int i = 0; i < n; i++) fr[i] = body[i];
    c = crc16(body, n);
    if (!good_crc) c = c ^ (16'h1 << $urandom_range(0, 15));
    fr[n] = c[7:0];
    fr[n + 1] = c[15:8];
    for (int i = 0; i < n + 2; i++) begin
      it.data = fr[i];
      it.last = (i == n + 1);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic queue_request(input logic [7:0] fc, input logic [7:0] a,
                               input logic [7:0] b4, input logic [7:0] b5,
                               input int nwords, input bit good_crc);
    logic [7:0] body[];
    int         n;
    n = (fc == mrs_pkg::FC_WRITE_MULTI) ? 7 + 2 * nwords : 6;
    body = new[n];
    body[0] = 8'($urandom);
    body[1] = fc;
    body[2] = 8'($urandom);
    body[3] = a;
    body[4] = b4;
    body[5] = b5;
    if (fc == mrs_pkg::FC_WRITE_MULTI) begin
      body[6] = 8'(2 * nwords);
      for (int i = 7; i < n; i++) body[i] = 8'($urandom);
    end
    queue_frame(body, good_crc);
  endtask

  task automatic queue_noise(input int n);
    rx_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data = 8'($urandom);
      it.last = (i == n - 1);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_reply.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_station(input logic [7:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    station_id = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The driver acts at the falling edge, so it needs the stall seen at the
  // preceding rising edge; rx_stall_q carries exactly that value.
  logic rx_stall_q;
  always @(posedge clk) rx_stall_q <= rx_stall;

  task automatic drive_next();
    rx_item_t it;
    it = pending_bytes.pop_front();
    rx_valid <= 1'b1;
    rx_byte <= it.data;
    frame_end <= it.last;
  endtask

  // Request driver: idles at random between transfers.
  int gap_left;
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      gap_left <= 0;
    end else if (rx_valid && !rx_stall_q) begin
      if (gap_left == 0 && !hold_sender && pending_bytes.size() != 0 &&
          $urandom_range(0, 2) != 0) begin
        drive_next();
      end else begin
        rx_valid <= 1'b0;
        gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      end
    end else if (!rx_valid) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (!hold_sender && pending_bytes.size() != 0) drive_next();
    end
  end

  // Reply stall generator.
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      tx_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      tx_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      tx_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end else tx_stall <= 1'b0;
  end

  // Monitor: predicts on request transfers and checks reply transfers.
  always @(posedge clk) begin
    reply_byte_t e;
    if (!rst) begin
      cycles <= cycles + 1;
      if (rx_valid && !rx_stall) predict_reply(rx_byte, frame_end);
      if (tx_valid && !tx_stall) begin
        if (expected_reply.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply byte %02h last %0b", tx_byte, tx_last);
        end else begin
          e = expected_reply.pop_front();
          if (e.data !== tx_byte || e.last !== tx_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: expected %02h/%0b got %02h/%0b",
                       e.data, e.last, tx_byte, tx_last);
          end
        end
      end
      if (cycles > LIMIT) begin
        $display("modbus_rtu_slave_register_file_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    int         sel, k, nw;
    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = 8'h00;
    frame_end = 1'b0;
    tx_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    hold_sender = 1'b0;
    mismatches = 0;
    cycles = 0;
    station_id = 8'd1;
    frame_len = 0;
    frame_ovf = 1'b0;
    for (int i = 0; i < NREGS; i++) begin
      regs_shadow[i] = 16'h0000;
      dirty_shadow[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    queue_request(mrs_pkg::FC_READ, 8'd0, 8'h00, 8'd3, 0, 1);
    queue_request(mrs_pkg::FC_WRITE_SINGLE, 8'd0, 8'hFF, 8'hFF, 0, 1);
    queue_request(mrs_pkg::FC_WRITE_SINGLE, 8'd0, 8'hFF, 8'hFF, 0, 1);
    queue_request(mrs_pkg::FC_WRITE_SINGLE, 8'd79, 8'h12, 8'h34, 0, 1);
    queue_request(mrs_pkg::FC_WRITE_MULTI, 8'd76, 8'h00, 8'd5, 5, 1);
    queue_request(mrs_pkg::FC_WRITE_MULTI, 8'd10, 8'h00, 8'd4, 1, 1);
    queue_request(mrs_pkg::FC_READ, 8'd70, 8'h00, 8'd255, 0, 1);
    queue_request(mrs_pkg::FC_READ, 8'd0, 8'h00, 8'd0, 0, 1);
    queue_request(mrs_pkg::FC_READ, 8'd0, 8'h00, 8'd29, 0, 0);
    queue_request(8'h42, 8'd0, 8'h00, 8'd1, 0, 1);
    queue_noise(5);
    queue_noise(1);
    drain();

    write_station(8'd247);
    hold_sender = 1'b1;
    queue_request(mrs_pkg::FC_READ, 8'd0, 8'h00, 8'd29, 0, 1);
    hold_sender = 1'b0;
    drain();
    write_station(8'd0);

    // Random part: a couple of short requests, now and then with a broken CRC.
    for (k = 0; k < 2; k++) begin
      sel = $urandom_range(0, 2);
      nw = $urandom_range(0, 2);
      queue_request(sel == 0 ? mrs_pkg::FC_READ
                    : sel == 1 ? mrs_pkg::FC_WRITE_SINGLE : mrs_pkg::FC_WRITE_MULTI,
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 82)),
                    8'($urandom), 8'(nw), nw, $urandom_range(0, 9) != 0);
    end
    drain();
    write_station(8'd1);

    if (mismatches == 0 && expected_reply.size() == 0)
      $display("modbus_rtu_slave_register_file_core verification clean");
    else
      $display("modbus_rtu_slave_register_file_core verification failed");
    $finish;
  end

endmodule
`default_nettype wire
